// File: hw/rtl/i2c_address_slot_cache_top_macros.svh
// Assertion macros for the I2C address slot cache.
// Used by i2c_address_slot_cache_top; empty when SYNTHESIS is defined.
// Depends on nothing.
`ifndef I2C_ADDRESS_SLOT_CACHE_TOP_MACROS_SVH
`define I2C_ADDRESS_SLOT_CACHE_TOP_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define ASC_ASSERT_SAME(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("slot cache assertion failed");

// Next-cycle implication.
`define ASC_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("slot cache assertion failed");

// Implication checked during reset as well.
`define ASC_ASSERT_ALWAYS(name, clk, ante, cons) \
   name: assert property (@(posedge clk) (ante) |-> (cons)) \
      else $error("slot cache assertion failed");

`else

`define ASC_ASSERT_SAME(name, clk, rst, ante, cons)
`define ASC_ASSERT_NEXT(name, clk, rst, ante, cons)
`define ASC_ASSERT_ALWAYS(name, clk, ante, cons)

`endif

`endif

// File: hw/rtl/asc_pkg.sv
// Package for the I2C address slot cache: widths, default slot counts, packing constants.
// Depends on nothing.
package asc_pkg;

   localparam int SLOT_COUNT_DEF      = 4;
   localparam int BUS0_SLOT_COUNT_DEF = 3;

   localparam int ADDR_W       = 7;
   localparam int RANK_W       = 3;
   localparam int SLOT_INDEX_W = 2;
   localparam int WORD_W       = 32;
   localparam int BYTE_W       = 8;
   localparam int WORD_BYTES   = WORD_W / BYTE_W;

   localparam logic [RANK_W-1:0] RANK_MAX    = 3'd7;
   localparam logic [RANK_W-1:0] RANK_ZERO   = 3'd0;
   localparam logic [RANK_W-1:0] RANK_FIRST  = 3'd1;
   localparam logic [WORD_W-1:0] LOOKUP_FLAG = 32'h8000_0000;

   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [RANK_W-1:0] rank_type;

endpackage

// File: hw/rtl/i2c_address_slot_cache_top.sv
// Channel | Ports                                         | Direction
// req     | req_valid, req_stall, req_device_address,     | in (stall out)
//         | req_bus_number                                |
// rsp     | rsp_valid, rsp_stall, rsp_slot_index,         | out (stall in)
//         | rsp_lookup_word                               |
// One beat per cycle unless stalled; a req beat goes via the input and result registers to rsp.
// The slot table (address, bus, rank) updates in the cycle the beat leaves the input register.
// Synchronous reset clears the table and both valid flags.
// A stall on rsp holds the result register and then the input register, backing up to req_stall.
// Depends on asc_pkg and i2c_address_slot_cache_top_macros.svh.
`include "i2c_address_slot_cache_top_macros.svh"

module i2c_address_slot_cache_top #(
   parameter int SLOT_COUNT      = asc_pkg::SLOT_COUNT_DEF,
   parameter int BUS0_SLOT_COUNT = asc_pkg::BUS0_SLOT_COUNT_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [asc_pkg::ADDR_W-1:0]         req_device_address,
   input  logic                               req_bus_number,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [asc_pkg::SLOT_INDEX_W-1:0]   rsp_slot_index,
   output logic [asc_pkg::WORD_W-1:0]         rsp_lookup_word
);
   import asc_pkg::*;

   localparam int B0_LIMIT = (BUS0_SLOT_COUNT > SLOT_COUNT) ? SLOT_COUNT : BUS0_SLOT_COUNT;
   localparam int SHOWN    = (SLOT_COUNT < WORD_BYTES) ? SLOT_COUNT : WORD_BYTES;

   logic                    s1_valid_ff;
   addr_type                s1_addr_ff;
   logic                    s1_bus_ff;
   logic                    rsp_valid_ff;
   logic [SLOT_INDEX_W-1:0] rsp_slot_ff;
   logic [WORD_W-1:0]       rsp_word_ff;

   addr_type                addr_ff [SLOT_COUNT];
   addr_type                addr_in [SLOT_COUNT];
   logic [SLOT_COUNT-1:0]   bus_ff;
   logic [SLOT_COUNT-1:0]   bus_in;
   rank_type                rank_ff [SLOT_COUNT];
   rank_type                rank_in [SLOT_COUNT];

   logic                    advance;
   logic                    move;
   logic [SLOT_COUNT-1:0]   usable;
   logic [SLOT_COUNT-1:0]   hit_sel;
   logic [SLOT_COUNT-1:0]   up_sel;
   logic [SLOT_COUNT-1:0]   victim_sel;
   logic [SLOT_COUNT-1:0]   chosen_sel;
   logic                    hit;
   logic                    up_found;
   logic                    victim_found;
   rank_type                hit_rank;
   logic [RANK_W:0]         rank_up;
   rank_type                lowest;
   logic [SLOT_INDEX_W-1:0] slot_in;
   logic [WORD_W-1:0]       word_in;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign move      = s1_valid_ff && advance;
   assign req_stall = s1_valid_ff && !advance;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_slot_index  = rsp_slot_ff;
   assign rsp_lookup_word = rsp_word_ff;

   always_comb begin
      hit          = 1'b0;
      hit_sel      = '0;
      up_found     = 1'b0;
      up_sel       = '0;
      victim_found = 1'b0;
      victim_sel   = '0;
      hit_rank     = RANK_ZERO;
      lowest       = RANK_MAX;
      slot_in      = '0;
      word_in      = '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
         usable[i] = s1_bus_ff || (i < B0_LIMIT);
         if (!hit && usable[i] && addr_ff[i] == s1_addr_ff && bus_ff[i] == s1_bus_ff) begin
            hit        = 1'b1;
            hit_sel[i] = 1'b1;
         end
      end
      for (int i = 0; i < SLOT_COUNT; i++) begin
         if (hit_sel[i]) begin
            hit_rank = hit_rank | rank_ff[i];
         end
      end
      rank_up = {1'b0, hit_rank} + 1'b1;
      for (int i = 0; i < SLOT_COUNT; i++) begin
         if (!up_found && usable[i] && {1'b0, rank_ff[i]} == rank_up) begin
            up_found  = 1'b1;
            up_sel[i] = 1'b1;
         end
         if (usable[i] && rank_ff[i] < lowest) begin
            lowest = rank_ff[i];
         end
      end
      for (int i = 0; i < SLOT_COUNT; i++) begin
         if (!victim_found && usable[i] && rank_ff[i] == lowest) begin
            victim_found  = 1'b1;
            victim_sel[i] = 1'b1;
         end
      end
      chosen_sel = hit ? hit_sel : victim_sel;

      for (int i = 0; i < SLOT_COUNT; i++) begin
         addr_in[i] = addr_ff[i];
         bus_in[i]  = bus_ff[i];
         rank_in[i] = rank_ff[i];
         if (hit) begin
            if (up_found && up_sel[i]) begin
               rank_in[i] = hit_rank;
            end
            if (up_found && hit_sel[i]) begin
               rank_in[i] = rank_up[RANK_W-1:0];
            end
         end else begin
            if (lowest == RANK_ZERO && usable[i] && rank_ff[i] != RANK_ZERO
                && rank_ff[i] != RANK_MAX) begin
               rank_in[i] = rank_ff[i] + 1'b1;
            end
            if (victim_sel[i]) begin
               addr_in[i] = s1_addr_ff;
               bus_in[i]  = s1_bus_ff;
               if (lowest == RANK_ZERO) begin
                  rank_in[i] = RANK_FIRST;
               end
            end
         end
         if (chosen_sel[i]) begin
            slot_in = slot_in | SLOT_INDEX_W'(i);
         end
      end
      for (int i = 0; i < SHOWN; i++) begin
         word_in[BYTE_W*i +: BYTE_W] = {bus_in[i], addr_in[i]};
      end
      word_in = word_in | LOOKUP_FLAG;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         bus_ff       <= '0;
         for (int i = 0; i < SLOT_COUNT; i++) begin
            addr_ff[i] <= '0;
            rank_ff[i] <= RANK_ZERO;
         end
      end else begin
         if (!req_stall) begin
            s1_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= s1_valid_ff;
         end
         if (move) begin
            bus_ff <= bus_in;
            for (int i = 0; i < SLOT_COUNT; i++) begin
               addr_ff[i] <= addr_in[i];
               rank_ff[i] <= rank_in[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         s1_addr_ff <= req_device_address;
         s1_bus_ff  <= req_bus_number;
      end
      if (move) begin
         rsp_slot_ff <= slot_in;
         rsp_word_ff <= word_in;
      end
   end

   `ASC_ASSERT_SAME(a_one_slot_chosen, clock, reset, s1_valid_ff, $onehot(chosen_sel))
   `ASC_ASSERT_SAME(a_backpressure, clock, reset, rsp_valid && rsp_stall && s1_valid_ff, req_stall)
   `ASC_ASSERT_NEXT(a_move_fills_rsp, clock, reset, move, rsp_valid_ff && rsp_word_ff[WORD_W-1])
   `ASC_ASSERT_ALWAYS(a_reset_clears, clock, $past(reset), !rsp_valid_ff && !s1_valid_ff)

endmodule
